FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: rtl/core/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Word types, command and status codes, and the cell control group.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam logic [2:0] CMD_APPEND  = 3'd0;
   localparam logic [2:0] CMD_PREPEND = 3'd1;
   localparam logic [2:0] CMD_DELETE  = 3'd2;
   localparam logic [2:0] CMD_FIND    = 3'd3;
   localparam logic [2:0] CMD_SINSERT = 3'd4;
   localparam logic [2:0] CMD_SDELETE = 3'd5;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_DUP       = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [3:0] position;
      logic [4:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic stop_on_gt;
      logic shift_in;
      logic shift_out;
   } cell_ctl_type;

endpackage

FILE: rtl/core/ole_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one key, compares it with the command key, extends the first-stop
// chain and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module ole_cell #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                        clock,
   input  ole_pkg::cell_ctl_type       ctl,
   input  logic signed [KEY_WIDTH-1:0] cmd_key,
   input  logic signed [KEY_WIDTH-1:0] left_key,
   input  logic signed [KEY_WIDTH-1:0] right_key,
   input  logic                        occ,
   input  logic                        seen_in,
   input  logic                        tgt,
   input  logic                        tgt_prev,
   output logic signed [KEY_WIDTH-1:0] key_out,
   output logic                        eq,
   output logic                        gt,
   output logic                        lt,
   output logic                        stop,
   output logic                        seen_out
);

   logic signed [KEY_WIDTH-1:0] key_ff;
   logic signed [KEY_WIDTH-1:0] key_in;

   always_comb begin
      key_in = key_ff;
      if (ctl.shift_in) begin
         if (tgt_prev) begin
            key_in = left_key;
         end else if (tgt) begin
            key_in = cmd_key;
         end
      end else if (ctl.shift_out && tgt) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out  = key_ff;
   assign eq       = occ && (key_ff == cmd_key);
   assign gt       = occ && (key_ff > cmd_key);
   assign lt       = occ && (key_ff < cmd_key);
   assign stop     = eq || (ctl.stop_on_gt && gt);
   assign seen_out = seen_in || stop;

endmodule

FILE: rtl/core/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// A word is taken only in idle. The exec state runs the compare, the first-stop
// chain through all cells and the shift in one step; it waits while an earlier
// response is held, then registers the result and returns to idle.
// Reset clears the entry count and the handshake state; cell keys are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_engine #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ole_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ole_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = $clog2(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef enum logic [1:0] {
      TGT_TAIL,
      TGT_ALL,
      TGT_SEEN
   } tgt_mode_type;

   state_type                   state_ff, state_in;
   logic [2:0]                  cmd_ff;
   logic signed [KEY_WIDTH-1:0] key_ff, key_conv;
   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ole_pkg::rsp_type            rsp_ff, rsp_in;

   ole_pkg::cell_ctl_type       ctl;
   logic signed [KEY_WIDTH-1:0] key_q [CAPACITY];
   logic [CAPACITY-1:0]         eq_v, gt_v, lt_v, stop_v, seen_v, occ_v, tgt_v;
   logic [CAPACITY-1:0]         seen_prev, occ_next, first_v, last_v;
   logic [PW-1:0]               pos_enc, pos_out;
   logic                        commit, full, any_stop, stop_is_eq, last_lt;
   logic                        do_ins, do_del, found;
   logic [1:0]                  status;
   tgt_mode_type                tgt_mode;

   generate
      if (KEY_WIDTH <= 32) begin : g_key_narrow
         assign key_conv = req_data.key[KEY_WIDTH-1:0];
      end else begin : g_key_wide
         assign key_conv = {{(KEY_WIDTH-32){req_data.key[31]}}, req_data.key};
      end
   endgenerate

   assign req_ready = (state_ff == S_IDLE);
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff >= CW'(CAPACITY));

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [KEY_WIDTH-1:0] left_key, right_key;
         logic                        seen_in, tgt_prev;
         if (gi == 0) begin : g_head
            assign left_key = key_ff;
            assign seen_in  = 1'b0;
            assign tgt_prev = 1'b0;
         end else begin : g_body
            assign left_key = key_q[gi-1];
            assign seen_in  = seen_v[gi-1];
            assign tgt_prev = tgt_v[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_key = key_q[gi];
         end else begin : g_mid
            assign right_key = key_q[gi+1];
         end
         assign occ_v[gi] = (count_ff > CW'(gi));

         ole_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .cmd_key   (key_ff),
            .left_key  (left_key),
            .right_key (right_key),
            .occ       (occ_v[gi]),
            .seen_in   (seen_in),
            .tgt       (tgt_v[gi]),
            .tgt_prev  (tgt_prev),
            .key_out   (key_q[gi]),
            .eq        (eq_v[gi]),
            .gt        (gt_v[gi]),
            .lt        (lt_v[gi]),
            .stop      (stop_v[gi]),
            .seen_out  (seen_v[gi])
         );
      end
   endgenerate

   assign seen_prev  = {seen_v[CAPACITY-2:0], 1'b0};
   assign occ_next   = {1'b0, occ_v[CAPACITY-1:1]};
   assign first_v    = stop_v & ~seen_prev;
   assign last_v     = occ_v & ~occ_next;
   assign any_stop   = seen_v[CAPACITY-1];
   assign stop_is_eq = |(first_v & eq_v);
   assign last_lt    = |(last_v & lt_v);

   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_v[i]) begin
            pos_enc = pos_enc | PW'(i);
         end
      end
   end

   always_comb begin
      do_ins   = 1'b0;
      do_del   = 1'b0;
      tgt_mode = TGT_SEEN;
      status   = ole_pkg::ST_NOT_FOUND;
      found    = 1'b0;
      pos_out  = '0;
      unique case (cmd_ff) inside
         ole_pkg::CMD_APPEND: begin
            if (full) begin
               status = ole_pkg::ST_FULL;
            end else begin
               do_ins   = 1'b1;
               tgt_mode = TGT_TAIL;
               pos_out  = PW'(count_ff);
               status   = ole_pkg::ST_DONE;
            end
         end
         ole_pkg::CMD_PREPEND: begin
            if (full) begin
               status = ole_pkg::ST_FULL;
            end else begin
               do_ins   = 1'b1;
               tgt_mode = TGT_ALL;
               status   = ole_pkg::ST_DONE;
            end
         end
         ole_pkg::CMD_DELETE, ole_pkg::CMD_FIND: begin
            if (any_stop) begin
               found   = 1'b1;
               pos_out = pos_enc;
               status  = ole_pkg::ST_DONE;
               do_del  = (cmd_ff == ole_pkg::CMD_DELETE);
            end
         end
         ole_pkg::CMD_SINSERT: begin
            if (count_ff == '0 || (!(occ_v[0] && gt_v[0]) && last_lt)) begin
               tgt_mode = TGT_TAIL;
               if (full) begin
                  status = ole_pkg::ST_FULL;
               end else begin
                  do_ins  = 1'b1;
                  pos_out = PW'(count_ff);
                  status  = ole_pkg::ST_DONE;
               end
            end else if (any_stop && stop_is_eq) begin
               status  = ole_pkg::ST_DUP;
               found   = 1'b1;
               pos_out = pos_enc;
            end else if (any_stop) begin
               if (full) begin
                  status = ole_pkg::ST_FULL;
               end else begin
                  do_ins  = 1'b1;
                  pos_out = pos_enc;
                  status  = ole_pkg::ST_DONE;
               end
            end
         end
         ole_pkg::CMD_SDELETE: begin
            if (any_stop && stop_is_eq) begin
               found   = 1'b1;
               pos_out = pos_enc;
               status  = ole_pkg::ST_DONE;
               do_del  = 1'b1;
            end
         end
         default: begin
            status = ole_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   always_comb begin
      ctl.stop_on_gt = (cmd_ff == ole_pkg::CMD_SINSERT) || (cmd_ff == ole_pkg::CMD_SDELETE);
      ctl.shift_in   = commit && do_ins;
      ctl.shift_out  = commit && do_del;
      case (tgt_mode)
         TGT_TAIL: tgt_v = ~occ_v;
         TGT_ALL:  tgt_v = '1;
         default:  tgt_v = seen_v;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               if (do_ins) begin
                  count_in = count_ff + CW'(1);
               end else if (do_del) begin
                  count_in = count_ff - CW'(1);
               end
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status;
               rsp_in.found         = found;
               rsp_in.position      = 4'(pos_out);
               rsp_in.entry_count   = 5'(count_in);
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         cmd_ff <= req_data.cmd;
         key_ff <= key_conv;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CW'(CAPACITY))
   `ASSERT_PROP(a_first_onehot, clock, reset, (state_ff == S_EXEC) |-> $onehot0(first_v))
   `ASSERT_PROP(a_stall_holds, clock, reset, (state_ff == S_EXEC && !commit) |=> $stable(count_ff))
   `ASSERT_PROP(a_commit_rsp, clock, reset, commit |=> (rsp_valid_ff && state_ff == S_IDLE))
   `ASSERT_NEVER(a_full, clock, reset, rsp_valid_ff && rsp_ff.status == ole_pkg::ST_FULL && !full)

endmodule
